// File: src/slfa_pkg.sv
// Shared types and constants for the slot free-stack allocator.
`default_nettype none

package slfa_pkg;

   localparam int OFFSET_W  = 18;
   localparam int SLOT_W    = 6;
   localparam int IN_USE_W  = 7;
   localparam int COUNT_W   = 7;
   localparam int ORDER_W   = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;

   localparam int MIN_ORDER = 3;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET   = 7'd64;
   localparam logic [ORDER_W-1:0] OBJECT_ORDER_RESET = 4'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_ORDER = 1'b1;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_NO_FREE       = 2'd1,
      ST_BAD_OFFSET    = 2'd2,
      ST_NOT_ALLOCATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OCC_EMPTY   = 2'd0,
      OCC_PARTIAL = 2'd1,
      OCC_FULL    = 2'd2
   } occupancy_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

endpackage

`default_nettype wire

// File: src/slfa_if.sv
// Request and response channel interfaces of the slot allocator.
`default_nettype none

interface slfa_req_if import slfa_pkg::*;;
   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [OFFSET_W-1:0] free_offset;

   modport source (output valid, output mode, output free_offset, input ready);
   modport sink   (input valid, input mode, input free_offset, output ready);
endinterface

interface slfa_rsp_if import slfa_pkg::*;;
   logic                valid;
   logic                ready;
   status_type          status;
   logic [SLOT_W-1:0]   slot;
   logic [OFFSET_W-1:0] object_offset;
   logic [IN_USE_W-1:0] in_use;
   occupancy_type       occupancy;

   modport source (output valid, output status, output slot, output object_offset,
                   output in_use, output occupancy, input ready);
   modport sink   (input valid, input status, input slot, input object_offset,
                   input in_use, input occupancy, output ready);
endinterface

`default_nettype wire

// File: src/slot_free_stack_allocator.sv
// Top level of the slot free-stack allocator: permutation stack and inverse table in RAM.
//
//   channel   dir   handshake       payload
//   req_chan  in    valid/ready     mode, free_offset
//   rsp_chan  out   valid/ready     status, slot, object_offset, in_use, occupancy
//   csr_*     in    csr_wr_en only  csr_index, csr_wr_data
//
// Allocate and rejected requests read both tables, then register the result;
// a committed free then writes a second pair to the stack and position RAMs in S_WB2.
// Synchronous reset; both tables read as identity until an entry is first written.
// A pending response stalls the block only at the cycle that produces the next one.
`default_nettype none

module slot_free_stack_allocator import slfa_pkg::*; #(
   parameter int MAX_SLOTS = 64,
   parameter int MAX_ORDER = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   slfa_req_if.sink                   req_chan,
   slfa_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int SW = $clog2(MAX_SLOTS);
   localparam int UW = $clog2(MAX_SLOTS + 1);
   localparam int OW = $clog2(MAX_ORDER + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WB2
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   slot_count_ff;
   logic [ORDER_W-1:0]   object_order_ff;
   logic [UW-1:0]        used_ff;
   mode_type             mode_ff;
   logic                 bad_ff;
   logic [SW-1:0]        idx_ff;
   logic [SW-1:0]        stack_raddr_ff;
   logic                 stack_rvld_ff;
   logic                 pos_rvld_ff;
   logic [SW-1:0]        last_ff;
   logic [SW-1:0]        moved_ff;
   logic [SW-1:0]        pos_ff;
   logic [MAX_SLOTS-1:0] stack_vld_ff;
   logic [MAX_SLOTS-1:0] pos_vld_ff;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [OFFSET_W-1:0]  rsp_offset_ff;
   logic [IN_USE_W-1:0]  rsp_in_use_ff;
   occupancy_type        rsp_occ_ff;

   logic [UW-1:0]        count_eff;
   logic [OW-1:0]        order_eff;
   logic                 req_accept;
   logic [31:0]          off_wide;
   logic [31:0]          idx_wide;
   logic [31:0]          align_mask;
   logic                 bad_in;
   logic [UW-1:0]        used_m1;
   logic [SW-1:0]        stack_raddr_in;

   logic [SW-1:0]        stack_rdata;
   logic [SW-1:0]        pos_rdata;
   logic [SW-1:0]        stack_val;
   logic [SW-1:0]        pos_val;

   logic                 go;
   logic                 free_commit;
   status_type           status_c;
   logic [SW-1:0]        slot_c;
   logic [UW-1:0]        used_in;
   occupancy_type        occ_c;
   logic [31:0]          slot_wide;
   logic [31:0]          offset_wide;
   logic [31:0]          used_wide;

   logic                 stack_we;
   logic [SW-1:0]        stack_waddr;
   logic [SW-1:0]        stack_wdata;
   logic                 pos_we;
   logic [SW-1:0]        pos_waddr;
   logic [SW-1:0]        pos_wdata;

   // saturated configuration
   always_comb begin
      if (slot_count_ff == '0) begin
         count_eff = UW'(1);
      end else if (32'(slot_count_ff) > 32'(MAX_SLOTS)) begin
         count_eff = UW'(MAX_SLOTS);
      end else begin
         count_eff = UW'(slot_count_ff);
      end
      if (32'(object_order_ff) < 32'(MIN_ORDER)) begin
         order_eff = OW'(MIN_ORDER);
      end else if (32'(object_order_ff) > 32'(MAX_ORDER)) begin
         order_eff = OW'(MAX_ORDER);
      end else begin
         order_eff = OW'(object_order_ff);
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE) && !reset;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      off_wide       = 32'(req_chan.free_offset);
      idx_wide       = off_wide >> order_eff;
      align_mask     = (32'd1 << order_eff) - 32'd1;
      bad_in         = ((off_wide & align_mask) != 32'd0) || (idx_wide >= 32'(count_eff));
      used_m1        = used_ff - UW'(1);
      stack_raddr_in = (req_chan.mode == MODE_FREE) ? used_m1[SW-1:0] : used_ff[SW-1:0];
   end

   slfa_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_en   (req_accept),
      .rd_addr (stack_raddr_in),
      .rd_data (stack_rdata)
   );

   slfa_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_en   (req_accept),
      .rd_addr (idx_wide[SW-1:0]),
      .rd_data (pos_rdata)
   );

   // unwritten entries read as identity
   assign stack_val = stack_rvld_ff ? stack_rdata : stack_raddr_ff;
   assign pos_val   = pos_rvld_ff ? pos_rdata : idx_ff;

   assign go          = (state_ff == S_EXEC) && !(rsp_valid_ff && !rsp_chan.ready);
   assign free_commit = (mode_ff == MODE_FREE) && !bad_ff && (UW'(pos_val) < used_ff);

   always_comb begin
      status_c = ST_OK;
      slot_c   = '0;
      used_in  = used_ff;
      if (mode_ff == MODE_ALLOC) begin
         if (used_ff >= count_eff) begin
            status_c = ST_NO_FREE;
         end else begin
            slot_c  = stack_val;
            used_in = used_ff + UW'(1);
         end
      end else if (bad_ff) begin
         status_c = ST_BAD_OFFSET;
      end else begin
         slot_c = idx_ff;
         if (free_commit) begin
            used_in = used_ff - UW'(1);
         end else begin
            status_c = ST_NOT_ALLOCATED;
         end
      end
      if (used_in == '0) begin
         occ_c = OCC_EMPTY;
      end else if (used_in >= count_eff) begin
         occ_c = OCC_FULL;
      end else begin
         occ_c = OCC_PARTIAL;
      end
      slot_wide   = 32'(slot_c);
      offset_wide = slot_wide << order_eff;
      used_wide   = 32'(used_in);
   end

   // swap writes: first pair on the result cycle, second pair in the next cycle, in S_WB2
   always_comb begin
      stack_we    = 1'b0;
      stack_waddr = pos_val;
      stack_wdata = stack_val;
      pos_we      = 1'b0;
      pos_waddr   = idx_ff;
      pos_wdata   = stack_raddr_ff;
      if (go && free_commit) begin
         stack_we = 1'b1;
         pos_we   = 1'b1;
      end else if (state_ff == S_WB2) begin
         stack_we    = 1'b1;
         stack_waddr = last_ff;
         stack_wdata = idx_ff;
         pos_we      = 1'b1;
         pos_waddr   = moved_ff;
         pos_wdata   = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         slot_count_ff   <= SLOT_COUNT_RESET;
         object_order_ff <= OBJECT_ORDER_RESET;
         used_ff         <= '0;
         stack_vld_ff    <= '0;
         pos_vld_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SLOT_COUNT:   slot_count_ff   <= csr_wr_data;
               CSR_OBJECT_ORDER: object_order_ff <= csr_wr_data[ORDER_W-1:0];
               default: ;
            endcase
         end
         if (stack_we) begin
            stack_vld_ff[stack_waddr] <= 1'b1;
         end
         if (pos_we) begin
            pos_vld_ff[pos_waddr] <= 1'b1;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (go) begin
                  used_ff  <= used_in;
                  state_ff <= free_commit ? S_WB2 : S_IDLE;
               end
            end
            S_WB2: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (req_accept) begin
         mode_ff        <= req_chan.mode;
         bad_ff         <= bad_in;
         idx_ff         <= idx_wide[SW-1:0];
         stack_raddr_ff <= stack_raddr_in;
         stack_rvld_ff  <= stack_vld_ff[stack_raddr_in];
         pos_rvld_ff    <= pos_vld_ff[idx_wide[SW-1:0]];
      end
      if (go) begin
         last_ff       <= stack_raddr_ff;
         moved_ff      <= stack_val;
         pos_ff        <= pos_val;
         rsp_status_ff <= status_c;
         rsp_slot_ff   <= slot_wide[SLOT_W-1:0];
         rsp_offset_ff <= offset_wide[OFFSET_W-1:0];
         rsp_in_use_ff <= used_wide[IN_USE_W-1:0];
         rsp_occ_ff    <= occ_c;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.slot          = rsp_slot_ff;
   assign rsp_chan.object_offset = rsp_offset_ff;
   assign rsp_chan.in_use        = rsp_in_use_ff;
   assign rsp_chan.occupancy     = rsp_occ_ff;

endmodule

`default_nettype wire

// File: src/slfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module slfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
